### hdl/spp_pkg.sv
// spike packet sync parser: shared types and constants
// used by spp_ctrl, spp_dp, spp_checker and the top level
package spp_pkg;

    localparam logic [1:0] REQ_PKT   = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_DRAIN = 2'd2;

    localparam logic [2:0] KIND_SPIKE  = 3'd0;
    localparam logic [2:0] KIND_HEADER = 3'd1;
    localparam logic [2:0] KIND_TIME   = 3'd2;
    localparam logic [2:0] KIND_BADLEN = 3'd3;
    localparam logic [2:0] KIND_XERR   = 3'd4;
    localparam logic [2:0] KIND_YERR   = 3'd5;

    localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_GRID_LENGTH = 2'd1;
    localparam logic [1:0] CFG_MAX_DELAY   = 2'd2;

    localparam int WRAP_GAP     = 30000;
    localparam int TIME_CAP     = 500000;
    localparam int SILENT_LIMIT = 10;
    localparam int RECIP_TEN    = 52429;
    localparam int DIV_STEPS    = 32;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

    typedef struct packed {
        logic accept;
        logic div_step;
        logic mul_step;
        logic fin_div;
        logic fin_tick;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic need_mul;
        logic out_free;
    } t_sts;

endpackage

### hdl/spp_ctrl.sv
// spike packet sync parser: sequencing state machine
// depends on spp_pkg; drives commands into spp_dp
module spp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  spp_pkg::t_sts  i_sts,
    output logic           o_in_stall,
    output spp_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]                    r_state, n_state;
    logic [spp_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                          r_is_div, n_is_div;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_is_div   = r_is_div;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = !i_sts.out_free;
                if (i_in_valid && i_sts.out_free) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.need_div) begin
                        n_state  = S_DIV;
                        n_cnt    = '0;
                        n_is_div = 1'b1;
                    end else if (i_sts.need_mul) begin
                        n_state  = S_MUL;
                        n_is_div = 1'b0;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == spp_pkg::DIV_CNT_W'(spp_pkg::DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin_div  = r_is_div;
                    o_cmd.fin_tick = !r_is_div;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_is_div <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_is_div <= n_is_div;
        end
    end

endmodule

### hdl/spp_dp.sv
// spike packet sync parser: datapath with parser state, divider,
// multiplier, config registers and output register; depends on spp_pkg
module spp_dp #(
    parameter int SPIKE_CAPACITY = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  spp_pkg::t_cmd  i_cmd,
    output spp_pkg::t_sts  o_sts,
    input  logic           i_cfg_valid,
    input  logic [1:0]     i_cfg_index,
    input  logic [12:0]    i_cfg_data,
    input  logic [1:0]     i_req_type,
    input  logic [7:0]     i_data_byte,
    input  logic           i_first_byte,
    input  logic [15:0]    i_packet_len,
    input  logic [31:0]    i_arrival_us,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    output logic [2:0]     o_result_kind,
    output logic [11:0]    o_spike_index,
    output logic [7:0]     o_spike_x,
    output logic [7:0]     o_spike_y,
    output logic [12:0]    o_spike_delay,
    output logic           o_sync_delay_flag,
    output logic [14:0]    o_step_count,
    output logic [14:0]    o_step_advance,
    output logic           o_buffer_was_reset,
    output logic [31:0]    o_compute_time_us
);

    localparam int TW = $clog2(SPIKE_CAPACITY + 1);

    logic [7:0]    r_grid_w, r_grid_l;
    logic [12:0]   r_max_delay;
    logic          r_running, r_first, r_step_acc, r_reset_pend;
    logic [14:0]   r_last_step;
    logic [31:0]   r_last_time, r_step_time, r_ptime;
    logic [19:0]   r_silent;
    logic [TW-1:0] r_total;
    logic [15:0]   r_byte_pos, r_bytes;
    logic [7:0]    r_header_low, r_rec_x, r_rec_y, r_rec_lsb;

    logic [31:0]   r_quo;
    logic [14:0]   r_rem, r_den;
    logic [38:0]   r_prod;
    logic          r_ovf;
    logic          r_h_flag, r_h_rst;
    logic [14:0]   r_h_step, r_h_adv;

    logic          r_out_valid;
    logic [2:0]    r_kind;
    logic [11:0]   r_idx;
    logic [7:0]    r_x, r_y;
    logic [12:0]   r_delay;
    logic          r_flag, r_bwr;
    logic [14:0]   r_step, r_adv;
    logic [31:0]   r_ctime;

    logic [14:0]   hdr_step, ls, diff, adv;
    logic [31:0]   lt;
    logic          pos_open, is_pkt, hdr_now, rec_now;
    logic [1:0]    off;
    logic [19:0]   sil_next;
    logic [15:0]   len_m2;
    logic          over;
    logic [31:0]   dprod;
    logic [12:0]   delay_q, delay_out;
    logic [TW:0]   tot_inc;
    logic [TW-1:0] tot_next;
    logic [15:0]   trial, r2, den16;
    logic          ge, up;
    logic [31:0]   rounded, tick_time;
    logic          load_out;

    logic          imm_ld;
    logic [2:0]    imm_kind;
    logic [11:0]   imm_idx;
    logic [7:0]    imm_x, imm_y;
    logic [12:0]   imm_delay;
    logic          imm_flag, imm_bwr;
    logic [14:0]   imm_step;
    logic [31:0]   imm_ctime;

    assign hdr_step = {i_data_byte, r_header_low[7:1]};
    assign ls       = r_first ? hdr_step : r_last_step;
    assign lt       = r_first ? r_ptime : r_last_time;
    assign diff     = hdr_step - ls;
    assign adv      = ((hdr_step > ls) || ((ls - hdr_step) > 15'(spp_pkg::WRAP_GAP)))
                      ? diff : 15'd0;
    assign pos_open = (r_byte_pos != 16'd0) && (r_byte_pos < r_bytes);
    assign is_pkt   = (i_req_type == spp_pkg::REQ_PKT) && r_running;
    assign hdr_now  = is_pkt && !i_first_byte && pos_open && (r_byte_pos == 16'd1);
    assign rec_now  = is_pkt && !i_first_byte && pos_open && (r_byte_pos != 16'd1);
    assign off      = r_byte_pos[1:0] ^ 2'b10;
    assign sil_next = (&r_silent) ? r_silent : r_silent + 20'd1;
    assign len_m2   = i_packet_len - 16'd2;
    assign over     = (17'(r_total) + 17'(len_m2[15:2])) > 17'(SPIKE_CAPACITY);
    assign dprod    = 32'({i_data_byte, r_rec_lsb}) * 32'(spp_pkg::RECIP_TEN);
    assign delay_q  = dprod[31:19];
    assign delay_out = (delay_q > r_max_delay) ? 13'd0 : delay_q;
    assign tot_inc  = {1'b0, r_total} + 1'b1;
    assign tot_next = (tot_inc >= (TW+1)'(SPIKE_CAPACITY)) ? '0 : tot_inc[TW-1:0];

    assign trial   = {r_rem, r_quo[31]};
    assign ge      = trial >= {1'b0, r_den};
    assign r2      = {r_rem, 1'b0};
    assign den16   = {1'b0, r_den};
    assign up      = (r2 > den16) || ((r2 == den16) && r_quo[0]);
    assign rounded = r_quo + 32'(up);
    assign tick_time = (r_ovf || (r_prod >= 39'(spp_pkg::TIME_CAP)))
                       ? 32'(spp_pkg::TIME_CAP) : r_prod[31:0];

    assign o_sts.need_div = hdr_now && (adv != 15'd0);
    assign o_sts.need_mul = (i_req_type == spp_pkg::REQ_TICK)
                            && (sil_next > 20'(spp_pkg::SILENT_LIMIT));
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        imm_ld    = 1'b0;
        imm_kind  = spp_pkg::KIND_SPIKE;
        imm_idx   = '0;
        imm_x     = '0;
        imm_y     = '0;
        imm_delay = '0;
        imm_flag  = 1'b0;
        imm_bwr   = 1'b0;
        imm_step  = '0;
        imm_ctime = '0;
        case (i_req_type)
            spp_pkg::REQ_PKT: begin
                if (is_pkt && i_first_byte) begin
                    if ((i_packet_len >= 16'd2) && (i_packet_len[1:0] != 2'b10)) begin
                        imm_ld   = 1'b1;
                        imm_kind = spp_pkg::KIND_BADLEN;
                    end
                end else if (hdr_now && (adv == 15'd0)) begin
                    imm_ld    = 1'b1;
                    imm_kind  = spp_pkg::KIND_HEADER;
                    imm_flag  = r_header_low[0];
                    imm_step  = hdr_step;
                    imm_bwr   = r_reset_pend;
                    imm_ctime = r_step_time;
                end else if (rec_now && r_step_acc) begin
                    if (off == 2'd0 && i_data_byte > r_grid_w) begin
                        imm_ld   = 1'b1;
                        imm_kind = spp_pkg::KIND_XERR;
                        imm_x    = i_data_byte;
                    end else if (off == 2'd1 && i_data_byte > r_grid_l) begin
                        imm_ld   = 1'b1;
                        imm_kind = spp_pkg::KIND_YERR;
                        imm_y    = i_data_byte;
                    end else if (off == 2'd3) begin
                        imm_ld    = 1'b1;
                        imm_kind  = spp_pkg::KIND_SPIKE;
                        imm_idx   = 12'(r_total);
                        imm_x     = r_rec_x;
                        imm_y     = r_rec_y;
                        imm_delay = delay_out;
                    end
                end
            end
            spp_pkg::REQ_TICK: begin
                if (!o_sts.need_mul) begin
                    imm_ld    = 1'b1;
                    imm_kind  = spp_pkg::KIND_TIME;
                    imm_ctime = r_step_time;
                end
            end
            default: begin
                imm_ld = 1'b0;
            end
        endcase
    end

    assign load_out = (i_cmd.accept && imm_ld) || i_cmd.fin_div || i_cmd.fin_tick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w     <= 8'd255;
            r_grid_l     <= 8'd255;
            r_max_delay  <= 13'd250;
            r_running    <= 1'b1;
            r_first      <= 1'b1;
            r_step_acc   <= 1'b0;
            r_reset_pend <= 1'b0;
            r_last_step  <= '0;
            r_last_time  <= '0;
            r_step_time  <= '0;
            r_ptime      <= '0;
            r_silent     <= '0;
            r_total      <= '0;
            r_byte_pos   <= '0;
            r_bytes      <= '0;
            r_header_low <= '0;
            r_rec_x      <= '0;
            r_rec_y      <= '0;
            r_rec_lsb    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    spp_pkg::CFG_GRID_WIDTH:  r_grid_w    <= i_cfg_data[7:0];
                    spp_pkg::CFG_GRID_LENGTH: r_grid_l    <= i_cfg_data[7:0];
                    spp_pkg::CFG_MAX_DELAY:   r_max_delay <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.fin_div) begin
                r_step_time <= rounded;
            end
            if (i_cmd.accept) begin
                case (i_req_type)
                    spp_pkg::REQ_PKT: begin
                        if (is_pkt && i_first_byte) begin
                            r_bytes      <= i_packet_len;
                            r_ptime      <= i_arrival_us;
                            r_header_low <= i_data_byte;
                            r_byte_pos   <= 16'd1;
                            r_step_acc   <= 1'b0;
                            r_reset_pend <= 1'b0;
                            if (i_packet_len < 16'd2) begin
                                r_byte_pos <= '0;
                                r_bytes    <= '0;
                            end else begin
                                r_silent <= '0;
                                if (i_packet_len[1:0] != 2'b10) begin
                                    r_running <= 1'b0;
                                end else if (over) begin
                                    r_total      <= '0;
                                    r_reset_pend <= 1'b1;
                                end
                            end
                        end else if (hdr_now) begin
                            r_byte_pos   <= 16'd2;
                            r_first      <= 1'b0;
                            r_last_step  <= hdr_step;
                            r_step_acc   <= (adv != 15'd0);
                            r_reset_pend <= 1'b0;
                            r_last_time  <= (adv != 15'd0) ? r_ptime : lt;
                        end else if (rec_now) begin
                            r_byte_pos <= r_byte_pos + 16'd1;
                            if (r_step_acc) begin
                                case (off)
                                    2'd0: begin
                                        if (i_data_byte > r_grid_w) begin
                                            r_running <= 1'b0;
                                        end else begin
                                            r_rec_x <= i_data_byte;
                                        end
                                    end
                                    2'd1: begin
                                        if (i_data_byte > r_grid_l) begin
                                            r_running <= 1'b0;
                                        end else begin
                                            r_rec_y <= i_data_byte;
                                        end
                                    end
                                    2'd2: r_rec_lsb <= i_data_byte;
                                    default: r_total <= tot_next;
                                endcase
                            end
                        end
                    end
                    spp_pkg::REQ_TICK: begin
                        r_silent <= sil_next;
                    end
                    spp_pkg::REQ_DRAIN: begin
                        r_total <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && o_sts.need_div) begin
            r_quo    <= r_ptime - lt;
            r_rem    <= '0;
            r_den    <= adv;
            r_h_flag <= r_header_low[0];
            r_h_step <= hdr_step;
            r_h_adv  <= adv;
            r_h_rst  <= r_reset_pend;
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? 15'(trial - den16) : trial[14:0];
            r_quo <= {r_quo[30:0], ge};
        end
        if (i_cmd.mul_step) begin
            r_prod <= 39'(r_silent) * 39'(r_step_time[18:0]);
            r_ovf  <= |r_step_time[31:19];
        end
        if (i_cmd.accept && imm_ld) begin
            r_kind  <= imm_kind;
            r_idx   <= imm_idx;
            r_x     <= imm_x;
            r_y     <= imm_y;
            r_delay <= imm_delay;
            r_flag  <= imm_flag;
            r_step  <= imm_step;
            r_adv   <= '0;
            r_bwr   <= imm_bwr;
            r_ctime <= imm_ctime;
        end else if (i_cmd.fin_div || i_cmd.fin_tick) begin
            r_kind  <= i_cmd.fin_div ? spp_pkg::KIND_HEADER : spp_pkg::KIND_TIME;
            r_idx   <= '0;
            r_x     <= '0;
            r_y     <= '0;
            r_delay <= '0;
            r_flag  <= i_cmd.fin_div & r_h_flag;
            r_step  <= i_cmd.fin_div ? r_h_step : 15'd0;
            r_adv   <= i_cmd.fin_div ? r_h_adv : 15'd0;
            r_bwr   <= i_cmd.fin_div & r_h_rst;
            r_ctime <= i_cmd.fin_div ? rounded : tick_time;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_result_kind      = r_kind;
    assign o_spike_index      = r_idx;
    assign o_spike_x          = r_x;
    assign o_spike_y          = r_y;
    assign o_spike_delay      = r_delay;
    assign o_sync_delay_flag  = r_flag;
    assign o_step_count       = r_step;
    assign o_step_advance     = r_adv;
    assign o_buffer_was_reset = r_bwr;
    assign o_compute_time_us  = r_ctime;

endmodule

### hdl/spike_packet_sync_parser_top.sv
// spike packet sync parser: top level, joins spp_ctrl and spp_dp
// depends on spp_pkg, spp_ctrl, spp_dp
//
//   channel   direction   handshake                   payload
//   in        sink        i_in_valid / o_in_stall     req_type .. arrival_us
//   out       source      o_out_valid / i_out_stall   result_kind .. compute_time_us
//   cfg       sink        i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// most items are handled straight from idle; a header that advances the step
// runs a 32-step restoring divider plus rounding, a tick past the silent limit
// runs one registered multiply; the output register holds one result
// while it is stalled no new item is taken; synchronous active-low reset
module spike_packet_sync_parser_top #(
    parameter int SPIKE_CAPACITY = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic [15:0] i_packet_len,
    input  logic [31:0] i_arrival_us,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_result_kind,
    output logic [11:0] o_spike_index,
    output logic [7:0]  o_spike_x,
    output logic [7:0]  o_spike_y,
    output logic [12:0] o_spike_delay,
    output logic        o_sync_delay_flag,
    output logic [14:0] o_step_count,
    output logic [14:0] o_step_advance,
    output logic        o_buffer_was_reset,
    output logic [31:0] o_compute_time_us,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);

    spp_pkg::t_cmd cmd;
    spp_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    spp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    spp_dp #(
        .SPIKE_CAPACITY (SPIKE_CAPACITY)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_req_type         (i_req_type),
        .i_data_byte        (i_data_byte),
        .i_first_byte       (i_first_byte),
        .i_packet_len       (i_packet_len),
        .i_arrival_us       (i_arrival_us),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_result_kind      (o_result_kind),
        .o_spike_index      (o_spike_index),
        .o_spike_x          (o_spike_x),
        .o_spike_y          (o_spike_y),
        .o_spike_delay      (o_spike_delay),
        .o_sync_delay_flag  (o_sync_delay_flag),
        .o_step_count       (o_step_count),
        .o_step_advance     (o_step_advance),
        .o_buffer_was_reset (o_buffer_was_reset),
        .o_compute_time_us  (o_compute_time_us)
    );

endmodule

### hdl/spp_checker.sv
// spike packet sync parser: port-level checks and their bind
// depends on spp_pkg and spike_packet_sync_parser_top
module spp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_result_kind,
    input logic [11:0] o_spike_index,
    input logic [12:0] o_spike_delay,
    input logic [14:0] o_step_count,
    input logic [31:0] o_compute_time_us
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("input taken while output full");

    a_spike_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == spp_pkg::KIND_SPIKE
        |-> o_spike_delay <= 13'd6553 && o_compute_time_us == 32'd0
            && o_step_count == 15'd0)
        else $error("bad spike fields");

    a_hdr_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind == spp_pkg::KIND_HEADER
            || o_result_kind == spp_pkg::KIND_TIME)
        |-> o_spike_index == 12'd0 && o_spike_delay == 13'd0)
        else $error("bad header fields");

endmodule

bind spike_packet_sync_parser_top spp_checker u_chk (.*);

### sim/tb_spike_packet_sync_parser_top.sv
// testbench for spike_packet_sync_parser_top: random packets, ticks and drains
// checked against a built-in parser model; depends on spp_pkg and the rtl
module tb_spike_packet_sync_parser_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  data_byte;
        logic        first_byte;
        logic [15:0] packet_len;
        logic [31:0] arrival_us;
    } t_req;

    typedef struct packed {
        logic [2:0]  kind;
        logic [11:0] index;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [12:0] delay;
        logic        flag;
        logic [14:0] step;
        logic [14:0] adv;
        logic        buf_reset;
        logic [31:0] ctime;
    } t_res;

    localparam int CAPACITY = 4096;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_req_type = '0;
    logic [7:0]  i_data_byte = '0;
    logic        i_first_byte = 1'b0;
    logic [15:0] i_packet_len = '0;
    logic [31:0] i_arrival_us = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_result_kind;
    logic [11:0] o_spike_index;
    logic [7:0]  o_spike_x;
    logic [7:0]  o_spike_y;
    logic [12:0] o_spike_delay;
    logic        o_sync_delay_flag;
    logic [14:0] o_step_count;
    logic [14:0] o_step_advance;
    logic        o_buffer_was_reset;
    logic [31:0] o_compute_time_us;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [12:0] i_cfg_data = '0;

    spike_packet_sync_parser_top DUT (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // parser model state
    logic [7:0]  m_grid_w, m_grid_l;
    logic [12:0] m_max_delay;
    bit          m_running, m_first, m_step_ok, m_reset_pend;
    logic [14:0] m_last_step;
    logic [31:0] m_last_time, m_step_time, m_pkt_time;
    logic [19:0] m_silent;
    int unsigned m_spikes, m_pos, m_len;
    logic [7:0]  m_hdr_low;
    logic [23:0] m_rec;

    t_req pending_q[$];
    t_res expected_q[$];
    int   errors = 0;
    int   hold_cycles = 0;

    logic [7:0]  m_cfg_w = 8'd255, m_cfg_l = 8'd255;

    function automatic logic [31:0] div_even(logic [31:0] num, logic [31:0] den);
        logic [63:0] q, r2;
        q = num / den;
        r2 = (num % den) * 2;
        if (r2 > den || (r2 == den && q[0])) q++;
        return q[31:0];
    endfunction

    task automatic push_kind(logic [2:0] k, output t_res r);
        r = '0;
        r.kind = k;
    endtask

    task automatic predict_parse(t_req q);
        t_res r;
        logic [14:0] stp;
        int unsigned adv, off, t;
        logic [63:0] p;
        if (q.req_type == spp_pkg::REQ_TICK) begin
            push_kind(spp_pkg::KIND_TIME, r);
            if (m_silent != 20'hFFFFF) m_silent++;
            r.ctime = m_step_time;
            if (m_silent > spp_pkg::SILENT_LIMIT) begin
                p = 64'(m_silent) * m_step_time;
                r.ctime = p < spp_pkg::TIME_CAP ? p[31:0] : spp_pkg::TIME_CAP;
            end
            expected_q.push_back(r);
            return;
        end
        if (q.req_type == spp_pkg::REQ_DRAIN) begin
            m_spikes = 0;
            return;
        end
        if (q.req_type != spp_pkg::REQ_PKT || !m_running) return;
        if (q.first_byte) begin
            m_len = q.packet_len;
            m_pkt_time = q.arrival_us;
            m_hdr_low = q.data_byte;
            m_pos = 1;
            m_step_ok = 0;
            m_reset_pend = 0;
            if (q.packet_len < 2) begin
                m_pos = 0;
                m_len = 0;
                return;
            end
            m_silent = 0;
            if (((q.packet_len - 2) & 3) != 0) begin
                m_running = 0;
                push_kind(spp_pkg::KIND_BADLEN, r);
                expected_q.push_back(r);
                return;
            end
            if (m_spikes + (q.packet_len - 2) / 4 > CAPACITY) begin
                m_spikes = 0;
                m_reset_pend = 1;
            end
            return;
        end
        if (m_pos == 0 || m_pos >= m_len) return;
        if (m_pos == 1) begin
            m_pos = 2;
            stp = {q.data_byte, m_hdr_low[7:1]};
            if (m_first) begin
                m_last_step = stp;
                m_last_time = m_pkt_time;
                m_first = 0;
            end
            adv = 0;
            if (stp > m_last_step) adv = stp - m_last_step;
            else if (m_last_step - stp > spp_pkg::WRAP_GAP) adv = 32768 - m_last_step + stp;
            m_last_step = stp;
            m_step_ok = adv > 0;
            if (adv > 0) begin
                m_step_time = div_even(m_pkt_time - m_last_time, adv);
                m_last_time = m_pkt_time;
            end
            push_kind(spp_pkg::KIND_HEADER, r);
            r.flag = m_hdr_low[0];
            r.step = stp;
            r.adv = adv[14:0];
            r.buf_reset = m_reset_pend;
            r.ctime = m_step_time;
            m_reset_pend = 0;
            expected_q.push_back(r);
            return;
        end
        off = (m_pos - 2) & 3;
        m_pos++;
        if (!m_step_ok) return;
        case (off)
            0: begin
                if (q.data_byte > m_grid_w) begin
                    m_running = 0;
                    push_kind(spp_pkg::KIND_XERR, r);
                    r.x = q.data_byte;
                    expected_q.push_back(r);
                end else m_rec = {16'h0, q.data_byte};
            end
            1: begin
                if (q.data_byte > m_grid_l) begin
                    m_running = 0;
                    push_kind(spp_pkg::KIND_YERR, r);
                    r.y = q.data_byte;
                    expected_q.push_back(r);
                end else m_rec[15:8] = q.data_byte;
            end
            2: m_rec[23:16] = q.data_byte;
            default: begin
                t = {q.data_byte, m_rec[23:16]} / 10;
                if (t > m_max_delay) t = 0;
                push_kind(spp_pkg::KIND_SPIKE, r);
                r.index = m_spikes[11:0];
                r.x = m_rec[7:0];
                r.y = m_rec[15:8];
                r.delay = t[12:0];
                expected_q.push_back(r);
                m_spikes++;
                if (m_spikes >= CAPACITY) m_spikes = 0;
            end
        endcase
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // driver
    int gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predict_parse({i_req_type, i_data_byte, i_first_byte,
                               i_packet_len, i_arrival_us});
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap > 0) begin
                    gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    t_req q;
                    q = pending_q.pop_front();
                    i_in_valid   <= 1'b1;
                    i_req_type   <= q.req_type;
                    i_data_byte  <= q.data_byte;
                    i_first_byte <= q.first_byte;
                    i_packet_len <= q.packet_len;
                    i_arrival_us <= q.arrival_us;
                    gap = ($urandom_range(0, 9) < 7) ? 0 :
                          ($urandom_range(0, 9) < 9 ? $urandom_range(1, 3)
                                                    : $urandom_range(10, 40));
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                t_res w;
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result kind", o_result_kind, 0);
                end else begin
                    w = expected_q.pop_front();
                    if (o_result_kind != w.kind) report_mismatch("kind", o_result_kind, w.kind);
                    if (o_spike_index != w.index) report_mismatch("index", o_spike_index, w.index);
                    if (o_spike_x != w.x) report_mismatch("x", o_spike_x, w.x);
                    if (o_spike_y != w.y) report_mismatch("y", o_spike_y, w.y);
                    if (o_spike_delay != w.delay) report_mismatch("delay", o_spike_delay, w.delay);
                    if (o_sync_delay_flag != w.flag)
                        report_mismatch("flag", o_sync_delay_flag, w.flag);
                    if (o_step_count != w.step) report_mismatch("step", o_step_count, w.step);
                    if (o_step_advance != w.adv) report_mismatch("advance", o_step_advance, w.adv);
                    if (o_buffer_was_reset != w.buf_reset)
                        report_mismatch("buffer reset", o_buffer_was_reset, w.buf_reset);
                    if (o_compute_time_us != w.ctime)
                        report_mismatch("compute time", o_compute_time_us, w.ctime);
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_stall <= 1'b1;
            end else if ($urandom_range(0, 99) < 4) begin
                hold_cycles = $urandom_range(5, 30);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 9) < 2);
            end
        end
    end

    function automatic t_req pkt_byte(logic [7:0] b, bit first, logic [15:0] len,
                                      logic [31:0] at);
        t_req q;
        q.req_type = spp_pkg::REQ_PKT;
        q.data_byte = b;
        q.first_byte = first;
        q.packet_len = len;
        q.arrival_us = at;
        return q;
    endfunction

    function automatic t_req ctl(logic [1:0] k);
        t_req q;
        q = '0;
        q.req_type = k;
        q.data_byte = 8'($urandom);
        q.packet_len = 16'($urandom);
        q.arrival_us = $urandom;
        return q;
    endfunction

    // queue one packet: recs records, header carrying step and flag
    task automatic add_packet(int recs, logic [14:0] stp, logic [31:0] at, int bad_xy);
        logic [15:0] hw;
        int len;
        len = 2 + 4 * recs;
        hw = {stp, 1'($urandom)};
        pending_q.push_back(pkt_byte(hw[7:0], 1, 16'(len), at));
        pending_q.push_back(pkt_byte(hw[15:8], 0, 16'($urandom), $urandom));
        for (int i = 0; i < recs; i++) begin
            for (int j = 0; j < 4; j++) begin
                logic [7:0] b;
                b = 8'($urandom);
                if (j == 0 && bad_xy != 1) b = 8'($urandom_range(0, m_cfg_w));
                if (j == 1 && bad_xy != 2) b = 8'($urandom_range(0, m_cfg_l));
                if (j == 3 && $urandom_range(0, 3) != 0) b = 8'($urandom_range(0, 9));
                pending_q.push_back(pkt_byte(b, 0, 16'($urandom), $urandom));
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_q.size() > 0 || i_in_valid || expected_q.size() > 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [12:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            spp_pkg::CFG_GRID_WIDTH:  begin m_grid_w = val[7:0]; m_cfg_w = val[7:0]; end
            spp_pkg::CFG_GRID_LENGTH: begin m_grid_l = val[7:0]; m_cfg_l = val[7:0]; end
            spp_pkg::CFG_MAX_DELAY:   m_max_delay = val;
            default: begin
            end
        endcase
    endtask

    initial begin
        logic [14:0] stp;
        logic [31:0] at;
        int n;
        m_grid_w = 255; m_grid_l = 255; m_max_delay = 250;
        m_running = 1; m_first = 1; m_last_step = 0; m_last_time = 0;
        m_step_time = 0; m_silent = 0; m_spikes = 0; m_pos = 0; m_len = 0;
        m_pkt_time = 0; m_hdr_low = 0; m_step_ok = 0; m_rec = 0; m_reset_pend = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: first packet, advances, wrap, ticks, drains, short packets
        stp = 100; at = 1000;
        add_packet(1, stp, at, 0);
        add_packet(2, stp + 15'd3, at + 3001, 0);
        add_packet(1, stp + 15'd3, at + 5000, 0);
        pending_q.push_back(pkt_byte(8'hFF, 1, 16'd1, 32'hFFFFFFFF));
        pending_q.push_back(pkt_byte(8'h00, 1, 16'd0, 32'h0));
        pending_q.push_back(pkt_byte(8'h55, 0, 16'd9, 32'h1));
        for (int i = 0; i < 12; i++) pending_q.push_back(ctl(spp_pkg::REQ_TICK));
        pending_q.push_back(ctl(spp_pkg::REQ_DRAIN));
        pending_q.push_back(ctl(2'd3));
        add_packet(1, 15'd32767, 32'hFFFFFF00, 0);
        add_packet(1, 15'd2, 32'h00000100, 0);
        wait_idle();

        write_reg(spp_pkg::CFG_GRID_WIDTH, 13'd0);
        write_reg(spp_pkg::CFG_GRID_LENGTH, 13'd0);
        write_reg(spp_pkg::CFG_MAX_DELAY, 13'd0);
        add_packet(2, 15'd10, 32'd50, 0);
        add_packet(1, 15'd20, 32'd70, 0);
        wait_idle();
        write_reg(spp_pkg::CFG_GRID_WIDTH, 13'd200);
        write_reg(spp_pkg::CFG_GRID_LENGTH, 13'd150);
        write_reg(spp_pkg::CFG_MAX_DELAY, 13'd6553);

        // random traffic; long receiver hold once
        n = 0;
        stp = 30; at = 12345;
        while (pending_q.size() + n < 850) begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 70) begin
                stp = stp + (($urandom_range(0, 9) == 0) ? 15'($urandom) :
                             15'($urandom_range(0, 3)));
                at = at + (($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 5000));
                add_packet($urandom_range(0, 9) == 0 ? $urandom_range(10, 30)
                                                      : $urandom_range(0, 4),
                           stp, at, 0);
            end else if (r < 85) pending_q.push_back(ctl(spp_pkg::REQ_TICK));
            else if (r < 90) pending_q.push_back(ctl(spp_pkg::REQ_DRAIN));
            else pending_q.push_back(pkt_byte(8'($urandom), 1'($urandom_range(0, 1)),
                                              16'($urandom_range(0, 3)), $urandom));
            if (pending_q.size() > 400) begin
                if (n == 0) hold_cycles = 300;
                n += pending_q.size();
                wait_idle();
            end
        end
        wait_idle();

        // big packet, then errors that stop the block
        write_reg(spp_pkg::CFG_GRID_WIDTH, 13'd255);
        write_reg(spp_pkg::CFG_GRID_LENGTH, 13'd255);
        write_reg(spp_pkg::CFG_MAX_DELAY, 13'd250);
        add_packet(200, stp + 15'd1, at + 999, 0);
        add_packet(2, stp + 15'd2, at + 1999, 0);
        wait_idle();
        write_reg(spp_pkg::CFG_GRID_WIDTH, 13'd7);
        write_reg(spp_pkg::CFG_GRID_LENGTH, 13'd7);
        add_packet(2, stp + 15'd3, at + 2999, 2);
        add_packet(1, stp + 15'd4, at + 3999, 0);
        pending_q.push_back(ctl(spp_pkg::REQ_TICK));
        wait_idle();

        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
